@@ rtl/rope_pkg.sv @@
// Shared constants for the rotary position embedding block.
`timescale 1ns / 1ps
`default_nettype none

package rope_pkg;

  // Fixed field widths
  localparam int POS_W      = 8;   // position of a result within the row
  localparam int TRIG_W     = 16;  // cos / sin, signed Q2.14
  localparam int FRAC_W     = 14;  // fraction bits of cos / sin
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_HALF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTARY_DIMS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_LENGTH = 2'd2;

  // Register reset values
  localparam logic                  RST_ROTATE_HALF = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RST_ROTARY_DIMS = 9'd64;
  localparam logic [CFG_DATA_W-1:0] RST_HEAD_LENGTH = 9'd64;

  // Result queue
  localparam int OUT_DEPTH  = 16;
  localparam int OUT_AW     = 4;
  localparam int OUT_CNT_W  = 5;

  // Kind of an item in the pipeline
  typedef enum logic {
    KIND_PASS = 1'b0,
    KIND_PAIR = 1'b1
  } item_kind_t;

endpackage

`default_nettype wire

@@ rtl/rope_ifs.sv @@
// Valid/ready channel interfaces: element input, result output, configuration.
`timescale 1ns / 1ps
`default_nettype none

interface rope_in_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] element_value;
  logic signed [15:0]   cos_value;
  logic signed [15:0]   sin_value;
  modport source (output valid, element_value, cos_value, sin_value, input ready);
  modport sink   (input valid, element_value, cos_value, sin_value, output ready);
endinterface

interface rope_out_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_position;
  logic signed [DW-1:0] out_value;
  logic                 row_done;
  modport source (output valid, out_position, out_value, row_done, input ready);
  modport sink   (input valid, out_position, out_value, row_done, output ready);
endinterface

interface rope_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/rope_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none

module rope_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/rotary_position_embedding_unit.sv @@
// Rotary position embedding: pairs head-row elements and rotates them by cos/sin.
//
// Usage:
//   elem   : one head-row element per word, in row order, with the cos and sin
//            of its pair's offset. Taken when valid and ready are both high.
//   result : rotated or passed-through values with their row position; row_done
//            marks the final word of a row.
//   cfg    : register writes (0 rotate-half layout, 1 rotary dims, 2 head length),
//            always ready. A write to a known register restarts the row.
// The first member of each pair is parked in the pending buffer RAM and read back
// when its partner arrives. The second member yields two result words, first the
// partner's rotated value, then its own. Pass-through elements yield one word.
// Each element passes through the buffer read, the products and the queue before its
// result word is valid; the second word of a pair follows.
// Throughput: one element per cycle; the result port drains one word per cycle,
// so in rotate-half layout the second half of the rotated span is paced by the
// result port once the 16-word result queue fills (two words per element there).
// elem.ready depends only on queue credit, never on result.ready combinationally.
// Reset: registers take 1 / 64 / 64, the row restarts, the queue empties; the
// pending buffer keeps no reset value. A stalled receiver uses up queue credit,
// then elem.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module rotary_position_embedding_unit #(
  parameter int MAX_HEAD_LEN = 256,
  parameter int DATA_BITS    = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  rope_in_if.sink   elem,
  rope_out_if.source result,
  rope_cfg_if.sink  cfg
);

  import rope_pkg::*;

  localparam int PEND_DEPTH = (MAX_HEAD_LEN / 2 > 1) ? MAX_HEAD_LEN / 2 : 1;
  localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int LEN_W      = ($clog2(MAX_HEAD_LEN + 1) > CFG_DATA_W + 1) ?
                              $clog2(MAX_HEAD_LEN + 1) : CFG_DATA_W + 1;
  localparam int PROD_W     = DATA_BITS + TRIG_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int Q_W        = SUM_W - FRAC_W;

  localparam logic [LEN_W-1:0]       MAX_LEN = LEN_W'(MAX_HEAD_LEN);
  localparam logic signed [SUM_W-1:0] RND    = SUM_W'(1 << (FRAC_W - 1));
  localparam logic signed [Q_W-1:0]   Q_HI   =
    {{(Q_W - DATA_BITS + 1){1'b0}}, {(DATA_BITS - 1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_LO   = ~Q_HI;

  // Round to nearest (half up), drop the fraction, saturate
  function automatic logic signed [DATA_BITS-1:0] round_sat(
    input logic signed [SUM_W-1:0] sum
  );
    logic signed [SUM_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    biased = sum + RND;
    q      = biased[SUM_W-1:FRAC_W];
    if (q > Q_HI) begin
      q = Q_HI;
    end else if (q < Q_LO) begin
      q = Q_LO;
    end
    return q[DATA_BITS-1:0];
  endfunction

  // Configuration registers and row position
  logic                  rotate_half;
  logic [CFG_DATA_W-1:0] rotary_dims;
  logic [CFG_DATA_W-1:0] head_length;
  logic [POS_W-1:0]      row_position;

  // Credit for result queue space (queued plus in flight)
  logic [OUT_CNT_W-1:0] credit;
  logic [OUT_CNT_W-1:0] credit_next;

  // Accept-stage decode
  logic                  accept;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      rot_even;
  logic [LEN_W-1:0]      rot;
  logic [LEN_W-1:0]      half;
  logic [POS_W-1:0]      half_pos;
  logic [LEN_W-1:0]      pos_ext;
  logic                  in_rot;
  logic                  is_first;
  logic                  is_last;
  logic [POS_W-1:0]      xpos;
  logic [POS_W-1:0]      wslot;
  logic [POS_W-1:0]      rslot;
  logic [1:0]            n_words;
  logic                  cfg_hit;
  logic                  pop;

  // Stage 1: buffer read in flight
  logic                        s1_valid;
  item_kind_t                  s1_kind;
  logic signed [DATA_BITS-1:0] s1_y;
  logic signed [TRIG_W-1:0]    s1_c;
  logic signed [TRIG_W-1:0]    s1_s;
  logic [POS_W-1:0]            s1_xpos;
  logic [POS_W-1:0]            s1_pos;
  logic                        s1_last;
  logic [DATA_BITS-1:0]        pend_rdata;

  // Stage 2: products registered
  logic                        s2_valid;
  item_kind_t                  s2_kind;
  logic signed [DATA_BITS-1:0] s2_y;
  logic signed [PROD_W-1:0]    s2_xc;
  logic signed [PROD_W-1:0]    s2_ys;
  logic signed [PROD_W-1:0]    s2_yc;
  logic signed [PROD_W-1:0]    s2_xs;
  logic [POS_W-1:0]            s2_xpos;
  logic [POS_W-1:0]            s2_pos;
  logic                        s2_last;
  logic signed [DATA_BITS-1:0] rot_first;
  logic signed [DATA_BITS-1:0] rot_second;

  // Result queue
  logic [POS_W-1:0]            q_pos  [OUT_DEPTH];
  logic signed [DATA_BITS-1:0] q_val  [OUT_DEPTH];
  logic                        q_done [OUT_DEPTH];
  logic [OUT_AW-1:0]           wr_ptr;
  logic [OUT_AW-1:0]           wr_ptr1;
  logic [OUT_AW-1:0]           rd_ptr;
  logic [OUT_CNT_W-1:0]        q_cnt;
  logic                        push0;
  logic                        push1;
  logic [POS_W-1:0]            push0_pos;
  logic signed [DATA_BITS-1:0] push0_val;
  logic                        push0_done;

  // Effective length and rotary span
  always_comb begin
    if (head_length == '0) begin
      len = LEN_W'(1);
    end else if (LEN_W'(head_length) > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = LEN_W'(head_length);
    end
    rot_even = LEN_W'({rotary_dims[CFG_DATA_W-1:1], 1'b0});
    rot      = (rot_even > len) ? {len[LEN_W-1:1], 1'b0} : rot_even;
    half     = rot >> 1;
    half_pos = half[POS_W-1:0];
    pos_ext  = LEN_W'(row_position);
  end

  // Pairing decode for the element at row_position
  always_comb begin
    in_rot   = pos_ext < rot;
    is_last  = (pos_ext + LEN_W'(1)) >= len;
    is_first = rotate_half ? (pos_ext < half) : ~row_position[0];
    xpos     = rotate_half ? (row_position - half_pos) : (row_position - POS_W'(1));
    wslot    = rotate_half ? row_position : (row_position >> 1);
    rslot    = rotate_half ? xpos : (row_position >> 1);
    if (!in_rot) begin
      n_words = 2'd1;
    end else if (is_first) begin
      n_words = 2'd0;
    end else begin
      n_words = 2'd2;
    end
  end

  assign elem.ready = credit <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign accept     = elem.valid && elem.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_hit    = cfg.valid && (cfg.index == REG_ROTATE_HALF ||
                                    cfg.index == REG_ROTARY_DIMS ||
                                    cfg.index == REG_HEAD_LENGTH);
  assign pop        = result.valid && result.ready;

  // Configuration writes and row tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_half  <= RST_ROTATE_HALF;
      rotary_dims  <= RST_ROTARY_DIMS;
      head_length  <= RST_HEAD_LENGTH;
      row_position <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_ROTATE_HALF: rotate_half <= cfg.data[0];
          REG_ROTARY_DIMS: rotary_dims <= cfg.data;
          REG_HEAD_LENGTH: head_length <= cfg.data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        row_position <= '0;
      end else if (accept) begin
        row_position <= is_last ? '0 : row_position + POS_W'(1);
      end
    end
  end

  // Pending first members; a partner always reads after its first member's write,
  // so the registered read needs no forwarding
  rope_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (PEND_DEPTH),
    .AW    (PEND_AW)
  ) u_pend (
    .clk   (clk),
    .we    (accept && in_rot && is_first),
    .waddr (PEND_AW'(wslot)),
    .wdata (elem.element_value),
    .raddr (PEND_AW'(rslot)),
    .rdata (pend_rdata)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (n_words != 2'd0);
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    s1_kind <= in_rot ? KIND_PAIR : KIND_PASS;
    s1_y    <= elem.element_value;
    s1_c    <= elem.cos_value;
    s1_s    <= elem.sin_value;
    s1_xpos <= xpos;
    s1_pos  <= row_position;
    s1_last <= is_last;
  end

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // Stage 2: the four products
  always_ff @(posedge clk) begin
    s2_xc   <= $signed(pend_rdata) * s1_c;
    s2_ys   <= s1_y * s1_s;
    s2_yc   <= s1_y * s1_c;
    s2_xs   <= $signed(pend_rdata) * s1_s;
    s2_kind <= s1_kind;
    s2_y    <= s1_y;
    s2_xpos <= s1_xpos;
    s2_pos  <= s1_pos;
    s2_last <= s1_last;
  end

  // Sum, round and saturate, then pick the words to queue
  always_comb begin
    rot_first  = round_sat(SUM_W'(s2_xc) - SUM_W'(s2_ys));
    rot_second = round_sat(SUM_W'(s2_yc) + SUM_W'(s2_xs));
    push0      = s2_valid;
    push1      = s2_valid && (s2_kind == KIND_PAIR);
    if (s2_kind == KIND_PAIR) begin
      push0_pos  = s2_xpos;
      push0_val  = rot_first;
      push0_done = 1'b0;
    end else begin
      push0_pos  = s2_pos;
      push0_val  = s2_y;
      push0_done = s2_last;
    end
  end

  assign wr_ptr1 = wr_ptr + OUT_AW'(1);

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push0) begin
      q_pos[wr_ptr]  <= push0_pos;
      q_val[wr_ptr]  <= push0_val;
      q_done[wr_ptr] <= push0_done;
    end
    if (push1) begin
      q_pos[wr_ptr1]  <= s2_pos;
      q_val[wr_ptr1]  <= rot_second;
      q_done[wr_ptr1] <= s2_last;
    end
  end

  // Result queue pointers, occupancy and credit
  always_comb begin
    credit_next = credit + (accept ? OUT_CNT_W'(n_words) : '0) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
      credit <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_AW'(push0) + OUT_AW'(push1);
      rd_ptr <= rd_ptr + OUT_AW'(pop);
      q_cnt  <= q_cnt + OUT_CNT_W'(push0) + OUT_CNT_W'(push1) - OUT_CNT_W'(pop);
      credit <= credit_next;
    end
  end

  assign result.valid        = q_cnt != '0;
  assign result.out_position = q_pos[rd_ptr];
  assign result.out_value    = q_val[rd_ptr];
  assign result.row_done     = q_done[rd_ptr];

`ifndef SYNTH
  // Credit never promises more space than the queue holds
  assert property (@(posedge clk) disable iff (rst)
    credit <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result credit above queue depth");

  // Queued words are always covered by credit
  assert property (@(posedge clk) disable iff (rst)
    q_cnt <= credit)
    else $error("result queue holds words without credit");

  // A push never lands on a full queue
  assert property (@(posedge clk) disable iff (rst)
    push0 |-> (q_cnt + OUT_CNT_W'(push1) + OUT_CNT_W'(1)
               <= OUT_CNT_W'(OUT_DEPTH) + OUT_CNT_W'(pop)))
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

@@ verif/rope_checker.sv @@
// Scoreboard for the rotary position embedding unit: predicts result words and compares them.
`timescale 1ns / 1ps

module rope_checker (
  input  logic clk,
  input  logic rst,
  rope_in_if   elem,
  rope_out_if  result,
  rope_cfg_if  cfg,
  output int   mismatch_count,
  output int   results_outstanding
);
  import rope_pkg::*;

  localparam int MAX_LEN    = 256;
  localparam int SLOT_COUNT = MAX_LEN / 2;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic signed [15:0] value;
    logic              row_done;
  } rope_word_t;

  // Expected result words, oldest first
  rope_word_t expected_words[$];

  // Shadow of the block: parked first members, registers, row position
  logic signed [15:0]    first_members [SLOT_COUNT];
  logic                  half_layout;
  logic [CFG_DATA_W-1:0] rotary_dims_reg;
  logic [CFG_DATA_W-1:0] head_length_reg;
  int unsigned           next_position;
  int                    failures;
  rope_word_t            got;
  rope_word_t            want;

  // Add the rounding bias, floor-shift by 14, clamp to 16 signed bits
  function automatic logic signed [15:0] round_saturate(input longint sum);
    longint q;
    q = (sum + 64'sd8192) >>> FRAC_W;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic push_word(input int unsigned pos, input logic signed [15:0] value,
                           input logic done);
    rope_word_t w;
    w.position = pos[POS_W-1:0];
    w.value    = value;
    w.row_done = done;
    expected_words.push_back(w);
  endtask

  // Work out the words caused by one accepted element
  task automatic rotate_element(input logic signed [15:0] e, input logic signed [15:0] c,
                                input logic signed [15:0] s);
    int unsigned eff_len;
    int unsigned rot;
    int unsigned half;
    int unsigned pos;
    int unsigned partner;
    logic        last;
    logic        is_first;
    longint      x;
    longint      y;
    eff_len = head_length_reg;
    if (eff_len == 0) eff_len = 1;
    if (eff_len > MAX_LEN) eff_len = MAX_LEN;
    rot = rotary_dims_reg & 9'h1FE;
    if (rot > eff_len) rot = eff_len & ~32'd1;
    half = rot / 2;
    pos  = next_position;
    last = (pos + 1 >= eff_len);
    if (pos < rot) begin
      is_first = half_layout ? (pos < half) : !pos[0];
      if (is_first) begin
        first_members[half_layout ? pos : pos / 2] = e;
      end else begin
        partner = half_layout ? pos - half : pos - 1;
        x = first_members[half_layout ? partner : partner / 2];
        y = e;
        push_word(partner, round_saturate(x * c - y * s), 1'b0);
        push_word(pos, round_saturate(y * c + x * s), last);
      end
    end else begin
      push_word(pos, e, last);
    end
    next_position = last ? 0 : (pos + 1) & 32'hFF;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      half_layout     = RST_ROTATE_HALF;
      rotary_dims_reg = RST_ROTARY_DIMS;
      head_length_reg = RST_HEAD_LENGTH;
      next_position   = 0;
      failures        = 0;
    end else begin
      // Compare an accepted result word with the oldest expectation
      if (result.valid && result.ready) begin
        got.position = result.out_position;
        got.value    = result.out_value;
        got.row_done = result.row_done;
        if (expected_words.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result word pos=%0d value=%0d done=%0b",
                     $realtime, got.position, got.value, got.row_done);
        end else begin
          want = expected_words.pop_front();
          if (got.position !== want.position || got.value !== want.value ||
              got.row_done !== want.row_done) begin
            failures++;
            if (failures <= 10)
              $display("%0t: result mismatch: expected pos=%0d value=%0d done=%0b, got pos=%0d value=%0d done=%0b",
                       $realtime, want.position, want.value, want.row_done,
                       got.position, got.value, got.row_done);
          end
        end
      end
      // Register write; any known register restarts the row
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ROTATE_HALF: half_layout = cfg.data[0];
          REG_ROTARY_DIMS: rotary_dims_reg = cfg.data;
          REG_HEAD_LENGTH: head_length_reg = cfg.data;
          default: ;
        endcase
        if (cfg.index == REG_ROTATE_HALF || cfg.index == REG_ROTARY_DIMS ||
            cfg.index == REG_HEAD_LENGTH)
          next_position = 0;
      end
      if (elem.valid && elem.ready)
        rotate_element(elem.element_value, elem.cos_value, elem.sin_value);
    end
    mismatch_count      <= failures;
    results_outstanding <= expected_words.size();
  end

endmodule

@@ verif/testbench.sv @@
// Top of the rotary position embedding testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import rope_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_TAIL  = 200;
  localparam int DRAIN_WAIT  = 8;

  logic clk;
  logic rst;
  int   items_sent;
  int   src_gap_pct;
  int   sink_stall_pct;
  int   sink_hold;
  int   idle_cycles;
  int   mismatch_count;
  int   results_outstanding;
  bit   quiet;
  int   gap_choices [4] = '{0, 5, 20, 50};

  rope_in_if  #(.DW(16)) elem_ch ();
  rope_out_if #(.DW(16)) result_ch ();
  rope_cfg_if            cfg_ch ();

  rotary_position_embedding_unit dut (
    .clk    (clk),
    .rst    (rst),
    .elem   (elem_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rope_checker scoreboard (
    .clk                 (clk),
    .rst                 (rst),
    .elem                (elem_ch),
    .result              (result_ch),
    .cfg                 (cfg_ch),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: ready with random stall bursts, none in the tail
  always @(posedge clk) begin
    if (rst) begin
      sink_hold = 0;
      result_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      result_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < sink_stall_pct) begin
      sink_hold = $urandom_range(13, 0);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((elem_ch.valid && elem_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic int effective_length(input int len_reg);
    if (len_reg == 0) return 1;
    if (len_reg > 256) return 256;
    return len_reg;
  endfunction

  function automatic logic [15:0] random_element();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_trig();
    case ($urandom_range(7))
      0: return 16'($urandom);
      1: return 16'h4000;
      2: return 16'hC000;
      default: return 16'($urandom_range(32768)) - 16'd16384;
    endcase
  endfunction

  // One element word; valid stays high across back-to-back words
  task automatic send_element(input logic [15:0] e, input logic [15:0] c,
                              input logic [15:0] s);
    quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
    if (!quiet && $urandom_range(99) < src_gap_pct) begin
      elem_ch.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.element_value <= e;
    elem_ch.cos_value     <= c;
    elem_ch.sin_value     <= s;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every expected word has arrived, then let the pipe drain
  task automatic settle();
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_config(input logic layout, input logic [8:0] rot,
                              input logic [8:0] len);
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      case (i)
        0: begin
          cfg_ch.index <= REG_ROTATE_HALF;
          cfg_ch.data  <= {8'd0, layout};
        end
        1: begin
          cfg_ch.index <= REG_ROTARY_DIMS;
          cfg_ch.data  <= rot;
        end
        default: begin
          cfg_ch.index <= REG_HEAD_LENGTH;
          cfg_ch.data  <= len;
        end
      endcase
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_rows(input int eff_len, input int rows);
    for (int r = 0; r < rows * eff_len; r++)
      send_element(random_element(), random_trig(), random_trig());
    elem_ch.valid <= 1'b0;
  endtask

  // New setting, then whole rows of random content
  task automatic run_phase(input logic layout, input int rot, input int len_reg,
                           input int rows);
    src_gap_pct    = gap_choices[$urandom_range(3)];
    sink_stall_pct = gap_choices[$urandom_range(3)];
    settle();
    write_config(layout, rot[8:0], len_reg[8:0]);
    send_rows(effective_length(len_reg), rows);
  endtask

  initial begin
    bit layout;
    int len_reg;
    int rot;
    int eff;
    items_sent     = 0;
    quiet          = 1'b0;
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    rst                   <= 1'b1;
    elem_ch.valid         <= 1'b0;
    elem_ch.element_value <= '0;
    elem_ch.cos_value     <= '0;
    elem_ch.sin_value     <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_ROTATE_HALF;
    cfg_ch.data           <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // One row under the reset setting (rotate-half, 64 of 64)
    send_rows(64, 1);

    // Rotate-half, 6 of 8: saturation both ways, zero sin, passes at the extremes
    settle();
    write_config(1'b1, 9'd6, 9'd8);
    send_element(16'h8000, 16'h0000, 16'h0000);
    send_element(16'h7FFF, 16'h0000, 16'h0000);
    send_element(16'd12345, 16'h0000, 16'h0000);
    send_element(16'h8000, 16'h4000, 16'hC000);
    send_element(16'h7FFF, 16'h4000, 16'h4000);
    send_element(16'hFFFF, 16'hC000, 16'h0000);
    send_element(16'h7FFF, 16'h4000, 16'h4000);
    send_element(16'h8000, 16'hC000, 16'hC000);
    elem_ch.valid <= 1'b0;

    // Adjacent pairs with odd rotary dims: rounding at one half, out-of-range cos/sin
    settle();
    write_config(1'b0, 9'd5, 9'd6);
    send_element(16'h0001, 16'h0000, 16'h0000);
    send_element(16'hFFFF, 16'h2000, 16'h0000);
    send_element(16'h8000, 16'h0000, 16'h0000);
    send_element(16'h7FFF, 16'h8000, 16'h7FFF);
    send_element(16'h0000, 16'h8000, 16'h7FFF);
    send_element(16'hFFFF, 16'h0000, 16'h0000);
    elem_ch.valid <= 1'b0;

    // Head length zero acts as one, rotary dims zero
    settle();
    write_config(1'b0, 9'd0, 9'd0);
    send_element(16'h1234, 16'h4000, 16'h4000);
    send_element(16'hFEDC, 16'hC000, 16'hC000);
    elem_ch.valid <= 1'b0;

    // Rotary dims beyond the row length
    settle();
    write_config(1'b1, 9'd9, 9'd3);
    send_element(16'h4000, 16'h2D41, 16'h2D41);
    send_element(16'hC000, 16'h2D41, 16'hD2BF);
    send_element(16'h5555, 16'h0000, 16'h0000);
    elem_ch.valid <= 1'b0;

    // Largest settings, one row each
    run_phase(1'b1, 256, 256, 1);
    run_phase(1'b0, 511, 511, 1);

    // Random settings, mostly short rows
    while (items_sent < ITEM_TARGET) begin
      layout = $urandom_range(1);
      case ($urandom_range(15))
        0: len_reg = 0;
        1: len_reg = $urandom_range(511, 257);
        2: len_reg = $urandom_range(256, 200);
        default: len_reg = $urandom_range(40, 1);
      endcase
      eff = effective_length(len_reg);
      case ($urandom_range(7))
        0: rot = 0;
        1: rot = $urandom_range(eff) | 1;
        2: rot = $urandom_range(511);
        default: rot = $urandom_range(eff) & ~1;
      endcase
      run_phase(layout, rot, len_reg, (eff > 64) ? 1 : $urandom_range(4, 1));
    end

    settle();
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
